// ===== design/deadband_change_reporter_defines.svh =====
// ----------------------------------------------------------------------------
// Deadband change reporter assertion macros
// Shared concurrent assertion forms for the reporter modules.
// ----------------------------------------------------------------------------
`ifndef DEADBAND_CHANGE_REPORTER_DEFINES_SVH
`define DEADBAND_CHANGE_REPORTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DCR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deadband change reporter: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define DCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deadband change reporter: next-cycle check failed");

`endif

// ===== design/dcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadband change reporter package
// Field widths, operation and result codes, register indexes and the types
// shared between the control register block, controller and datapath.
// ----------------------------------------------------------------------------
package dcr_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int TIME_W      = 32;
   localparam int CHAN_W      = 3;
   localparam int ROOM_W      = 3;
   localparam int MAX_CH      = 4;
   localparam int SMP_IDX_W   = 2;
   localparam int PADDR_W     = 5;
   localparam int PDATA_W     = 32;
   localparam int REG_IDX_W   = 3;

   localparam logic [ROOM_W-1:0] ROOM_MAX = 3'd4;

   localparam logic [1:0] OP_TICK        = 2'd0;
   localparam logic [1:0] OP_SUBSCRIBE   = 2'd1;
   localparam logic [1:0] OP_UNSUBSCRIBE = 2'd2;
   localparam logic [1:0] OP_READ        = 2'd3;

   localparam logic [1:0] KIND_EVENT   = 2'd0;
   localparam logic [1:0] KIND_ACK_OK  = 2'd1;
   localparam logic [1:0] KIND_ACK_ERR = 2'd2;

   localparam logic [REG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_0   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_1   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_2   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_3   = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PERIOD,
      ST_SCAN,
      ST_FLUSH,
      ST_ACK
   } dcr_state_type;

   typedef struct packed {
      logic [TIME_W-1:0]                 sample_period;
      logic [MAX_CH-1:0][SAMPLE_W-1:0]   threshold;
   } dcr_cfg_type;

   typedef struct packed {
      logic in_ready;
      logic load;
      logic sweep_start;
      logic advance;
      logic take;
      logic flush;
      logic ack;
   } dcr_cmd_type;

   typedef struct packed {
      logic in_valid;
      logic in_tick;
      logic due;
      logic hit;
      logic pend_valid;
      logic out_free;
      logic scan_end;
   } dcr_status_type;

endpackage

// ===== design/dcr_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadband change reporter request channel
// Valid/ready channel carrying one command or tick beat.
// ----------------------------------------------------------------------------
interface dcr_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           opcode;
   logic [dcr_pkg::CHAN_W-1:0]           channel;
   logic [dcr_pkg::TIME_W-1:0]           now_ms;
   logic signed [dcr_pkg::SAMPLE_W-1:0]  sample_0;
   logic signed [dcr_pkg::SAMPLE_W-1:0]  sample_1;
   logic signed [dcr_pkg::SAMPLE_W-1:0]  sample_2;
   logic signed [dcr_pkg::SAMPLE_W-1:0]  sample_3;
   logic [dcr_pkg::ROOM_W-1:0]           send_room;

   modport source (output valid, opcode, channel, now_ms, sample_0, sample_1,
                   sample_2, sample_3, send_room, input ready);
   modport sink   (input valid, opcode, channel, now_ms, sample_0, sample_1,
                   sample_2, sample_3, send_room, output ready);
endinterface

// ===== design/dcr_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadband change reporter response channel
// Valid/ready channel carrying one event or acknowledge beat.
// ----------------------------------------------------------------------------
interface dcr_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           kind;
   logic [dcr_pkg::CHAN_W-1:0]           source_channel;
   logic signed [dcr_pkg::SAMPLE_W-1:0]  reading;
   logic                                 last;

   modport source (output valid, kind, source_channel, reading, last,
                   input ready);
   modport sink   (input valid, kind, source_channel, reading, last,
                   output ready);
endinterface

// ===== design/deadband_change_reporter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadband change reporter
// Per-channel send-on-delta reporting engine with subscribe, unsubscribe
// and read commands, configured through an APB register port.
//
//   Port      Direction  Beat
//   req_bus   in         tick or single-channel command
//   rsp_bus   out        sensor event or acknowledge
//   p*        in/out     APB register access
//
// A tick passes through the period check, then steps through the channels
// one at a time in the single deadband compare unit, then sends the final
// event and returns to idle to accept the next beat; a tick within the
// period returns to idle after the check. A command is acknowledged, then idles.
// A new beat is accepted only while idle.
// A held result register stalls the channel scan and the acknowledge.
// Reset is synchronous and clears flags, baselines, sweep time and control
// state.
// ----------------------------------------------------------------------------
module deadband_change_reporter #(
   parameter int CHANNELS = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   dcr_req_if.sink                        req_bus,
   dcr_rsp_if.source                      rsp_bus,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [dcr_pkg::PADDR_W-1:0]    paddr,
   input  logic [dcr_pkg::PDATA_W-1:0]    pwdata,
   output logic [dcr_pkg::PDATA_W-1:0]    prdata,
   output logic                           pready
);

   dcr_pkg::dcr_cfg_type    cfg;
   dcr_pkg::dcr_cmd_type    cmd;
   dcr_pkg::dcr_status_type st;

   dcr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dcr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .cmd   (cmd)
   );

   dcr_datapath #(
      .CHANNELS (CHANNELS)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .cfg     (cfg),
      .cmd     (cmd),
      .st      (st)
   );

endmodule

// ===== design/dcr_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadband change reporter control registers
// APB register block holding the sample period and per-channel thresholds.
// ----------------------------------------------------------------------------
module dcr_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [dcr_pkg::PADDR_W-1:0]    paddr,
   input  logic [dcr_pkg::PDATA_W-1:0]    pwdata,
   output logic [dcr_pkg::PDATA_W-1:0]    prdata,
   output logic                           pready,
   output dcr_pkg::dcr_cfg_type           cfg
);

   dcr_pkg::dcr_cfg_type                  cfg_ff;
   dcr_pkg::dcr_cfg_type                  cfg_in;
   logic [dcr_pkg::REG_IDX_W-1:0]         reg_idx;
   logic                                  wr_en;

   assign reg_idx = paddr[dcr_pkg::PADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            dcr_pkg::REG_SAMPLE_PERIOD: cfg_in.sample_period = pwdata;
            dcr_pkg::REG_THRESHOLD_0:   cfg_in.threshold[0] = pwdata[15:0];
            dcr_pkg::REG_THRESHOLD_1:   cfg_in.threshold[1] = pwdata[15:0];
            dcr_pkg::REG_THRESHOLD_2:   cfg_in.threshold[2] = pwdata[15:0];
            dcr_pkg::REG_THRESHOLD_3:   cfg_in.threshold[3] = pwdata[15:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         dcr_pkg::REG_SAMPLE_PERIOD: prdata = cfg_ff.sample_period;
         dcr_pkg::REG_THRESHOLD_0:   prdata = {16'd0, cfg_ff.threshold[0]};
         dcr_pkg::REG_THRESHOLD_1:   prdata = {16'd0, cfg_ff.threshold[1]};
         dcr_pkg::REG_THRESHOLD_2:   prdata = {16'd0, cfg_ff.threshold[2]};
         dcr_pkg::REG_THRESHOLD_3:   prdata = {16'd0, cfg_ff.threshold[3]};
         default:                    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/dcr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadband change reporter controller
// State machine sequencing the period check, the channel scan, the final
// event flush and single-channel acknowledges.
// ----------------------------------------------------------------------------
`include "deadband_change_reporter_defines.svh"

module dcr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  dcr_pkg::dcr_status_type st,
   output dcr_pkg::dcr_cmd_type    cmd
);

   dcr_pkg::dcr_state_type state_ff;
   dcr_pkg::dcr_state_type state_in;
   logic                   scan_stall;

   assign scan_stall = st.hit && st.pend_valid && !st.out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dcr_pkg::ST_IDLE: begin
            if (st.in_valid) begin
               state_in = st.in_tick ? dcr_pkg::ST_PERIOD : dcr_pkg::ST_ACK;
            end
         end
         dcr_pkg::ST_PERIOD: begin
            state_in = st.due ? dcr_pkg::ST_SCAN : dcr_pkg::ST_IDLE;
         end
         dcr_pkg::ST_SCAN: begin
            if (!scan_stall && st.scan_end) begin
               state_in = dcr_pkg::ST_FLUSH;
            end
         end
         dcr_pkg::ST_FLUSH: begin
            if (!st.pend_valid || st.out_free) begin
               state_in = dcr_pkg::ST_IDLE;
            end
         end
         dcr_pkg::ST_ACK: begin
            if (st.out_free) begin
               state_in = dcr_pkg::ST_IDLE;
            end
         end
         default: state_in = dcr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         dcr_pkg::ST_IDLE: begin
            cmd.in_ready = 1'b1;
            cmd.load     = st.in_valid;
         end
         dcr_pkg::ST_PERIOD: begin
            cmd.sweep_start = st.due;
         end
         dcr_pkg::ST_SCAN: begin
            cmd.advance = !scan_stall;
            cmd.take    = st.hit && !scan_stall;
         end
         dcr_pkg::ST_FLUSH: begin
            cmd.flush = st.pend_valid && st.out_free;
         end
         dcr_pkg::ST_ACK: begin
            cmd.ack = st.out_free;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dcr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `DCR_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, cmd.load, (state_ff == dcr_pkg::ST_PERIOD) || (state_ff == dcr_pkg::ST_ACK))
   `DCR_ASSERT_NEXT(a_stall_holds_scan, clock, reset, (state_ff == dcr_pkg::ST_SCAN) && scan_stall, state_ff == dcr_pkg::ST_SCAN)

endmodule

// ===== design/dcr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadband change reporter datapath
// Latched request, per-channel flags and baselines, the shared deadband
// compare unit, the pending event register and the result register.
// ----------------------------------------------------------------------------
`include "deadband_change_reporter_defines.svh"

module dcr_datapath #(
   parameter int CHANNELS = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   dcr_req_if.sink                 req_bus,
   dcr_rsp_if.source               rsp_bus,
   input  dcr_pkg::dcr_cfg_type    cfg,
   input  dcr_pkg::dcr_cmd_type    cmd,
   output dcr_pkg::dcr_status_type st
);

   localparam int CurW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SmpIdxW = dcr_pkg::SMP_IDX_W;
   localparam int SampleW = dcr_pkg::SAMPLE_W;
   localparam int ChanW   = dcr_pkg::CHAN_W;
   localparam int RoomW   = dcr_pkg::ROOM_W;
   localparam int TimeW   = dcr_pkg::TIME_W;
   localparam logic [ChanW:0] ChanCount = (ChanW + 1)'(CHANNELS);
   localparam logic [CurW-1:0] CurLast  = CurW'(CHANNELS - 1);

   logic [1:0]                                    op_ff, op_in;
   logic [ChanW-1:0]                              chan_ff, chan_in;
   logic [TimeW-1:0]                              now_ff, now_in;
   logic signed [dcr_pkg::MAX_CH-1:0][SampleW-1:0] smp_ff, smp_in;
   logic [RoomW-1:0]                              room_ff, room_in;
   logic [TimeW-1:0]                              sweep_ff, sweep_in;
   logic [CurW-1:0]                               cur_ff, cur_in;
   logic [CHANNELS-1:0]                           sub_ff, sub_in;
   logic [CHANNELS-1:0]                           primed_ff, primed_in;
   logic [CHANNELS-1:0][SampleW-1:0]              base_ff, base_in;
   logic                                          pend_valid_ff, pend_valid_in;
   logic [CurW-1:0]                               pend_ch_ff, pend_ch_in;
   logic [SampleW-1:0]                            pend_val_ff, pend_val_in;
   logic                                          out_valid_ff, out_valid_in;
   logic [1:0]                                    out_kind_ff, out_kind_in;
   logic [ChanW-1:0]                              out_ch_ff, out_ch_in;
   logic [SampleW-1:0]                            out_val_ff, out_val_in;
   logic                                          out_last_ff, out_last_in;

   logic [SmpIdxW-1:0]     smp_idx;
   logic [SampleW-1:0]     smp_sel;
   logic [SampleW-1:0]     thr_sel;
   logic signed [SampleW:0] diff;
   logic [SampleW:0]       mag;
   logic                   exceeds;
   logic                   out_free;
   logic                   in_range;
   logic [TimeW-1:0]       elapsed;

   assign smp_idx  = SmpIdxW'(cur_ff);
   assign smp_sel  = smp_ff[smp_idx];
   assign thr_sel  = cfg.threshold[smp_idx];
   assign diff     = {smp_sel[SampleW-1], smp_sel} - {base_ff[cur_ff][SampleW-1], base_ff[cur_ff]};
   assign mag      = diff[SampleW] ? (SampleW + 1)'(-diff) : diff;
   assign exceeds  = mag >= {1'b0, thr_sel};
   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign in_range = {1'b0, chan_ff} < ChanCount;
   assign elapsed  = now_ff - sweep_ff;

   assign req_bus.ready          = cmd.in_ready;
   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.kind           = out_kind_ff;
   assign rsp_bus.source_channel = out_ch_ff;
   assign rsp_bus.reading        = out_val_ff;
   assign rsp_bus.last           = out_last_ff;

   always_comb begin
      st            = '0;
      st.in_valid   = req_bus.valid;
      st.in_tick    = req_bus.opcode == dcr_pkg::OP_TICK;
      st.due        = elapsed >= cfg.sample_period;
      st.hit        = sub_ff[cur_ff] && (!primed_ff[cur_ff] || exceeds) && (room_ff != '0);
      st.pend_valid = pend_valid_ff;
      st.out_free   = out_free;
      st.scan_end   = cur_ff == CurLast;
   end

   always_comb begin
      op_in         = op_ff;
      chan_in       = chan_ff;
      now_in        = now_ff;
      smp_in        = smp_ff;
      room_in       = room_ff;
      sweep_in      = sweep_ff;
      cur_in        = cur_ff;
      sub_in        = sub_ff;
      primed_in     = primed_ff;
      base_in       = base_ff;
      pend_valid_in = pend_valid_ff;
      pend_ch_in    = pend_ch_ff;
      pend_val_in   = pend_val_ff;
      out_valid_in  = out_valid_ff && !rsp_bus.ready;
      out_kind_in   = out_kind_ff;
      out_ch_in     = out_ch_ff;
      out_val_in    = out_val_ff;
      out_last_in   = out_last_ff;

      if (cmd.load) begin
         op_in     = req_bus.opcode;
         chan_in   = req_bus.channel;
         now_in    = req_bus.now_ms;
         smp_in[0] = req_bus.sample_0;
         smp_in[1] = req_bus.sample_1;
         smp_in[2] = req_bus.sample_2;
         smp_in[3] = req_bus.sample_3;
         room_in   = (req_bus.send_room > dcr_pkg::ROOM_MAX) ? dcr_pkg::ROOM_MAX
                                                            : req_bus.send_room;
         cur_in    = CurW'(req_bus.channel);
      end

      if (cmd.sweep_start) begin
         sweep_in      = now_ff;
         cur_in        = '0;
         pend_valid_in = 1'b0;
      end

      if (cmd.advance) begin
         cur_in = cur_ff + 1'b1;
      end

      if (cmd.take) begin
         base_in[cur_ff]   = smp_sel;
         primed_in[cur_ff] = 1'b1;
         room_in           = room_ff - 1'b1;
         pend_valid_in     = 1'b1;
         pend_ch_in        = cur_ff;
         pend_val_in       = smp_sel;
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_kind_in  = dcr_pkg::KIND_EVENT;
            out_ch_in    = ChanW'(pend_ch_ff);
            out_val_in   = pend_val_ff;
            out_last_in  = 1'b0;
         end
      end

      if (cmd.flush) begin
         out_valid_in  = 1'b1;
         out_kind_in   = dcr_pkg::KIND_EVENT;
         out_ch_in     = ChanW'(pend_ch_ff);
         out_val_in    = pend_val_ff;
         out_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end

      if (cmd.ack) begin
         out_valid_in = 1'b1;
         out_kind_in  = in_range ? dcr_pkg::KIND_ACK_OK : dcr_pkg::KIND_ACK_ERR;
         out_ch_in    = chan_ff;
         out_val_in   = (in_range && (op_ff == dcr_pkg::OP_READ)) ? smp_sel : '0;
         out_last_in  = 1'b1;
         if (in_range) begin
            case (op_ff)
               dcr_pkg::OP_SUBSCRIBE: begin
                  sub_in[cur_ff]    = 1'b1;
                  primed_in[cur_ff] = 1'b0;
               end
               dcr_pkg::OP_UNSUBSCRIBE: begin
                  sub_in[cur_ff] = 1'b0;
               end
               default: begin
                  sub_in = sub_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= '0;
         sub_ff        <= '0;
         primed_ff     <= '0;
         base_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         room_ff       <= '0;
      end else begin
         sweep_ff      <= sweep_in;
         sub_ff        <= sub_in;
         primed_ff     <= primed_in;
         base_ff       <= base_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         room_ff       <= room_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      chan_ff     <= chan_in;
      now_ff      <= now_in;
      smp_ff      <= smp_in;
      cur_ff      <= cur_in;
      pend_ch_ff  <= pend_ch_in;
      pend_val_ff <= pend_val_in;
      out_kind_ff <= out_kind_in;
      out_ch_ff   <= out_ch_in;
      out_val_ff  <= out_val_in;
      out_last_ff <= out_last_in;
   end

   `DCR_ASSERT_NOW(a_room_bounded, clock, reset, 1'b1, room_ff <= dcr_pkg::ROOM_MAX)
   `DCR_ASSERT_NOW(a_take_has_room, clock, reset, cmd.take, room_ff != '0)
   `DCR_ASSERT_NOW(a_flush_has_event, clock, reset, cmd.flush, pend_valid_ff && out_free)
   `DCR_ASSERT_NOW(a_load_when_free, clock, reset, (cmd.take && pend_valid_ff) || cmd.ack, out_free)

endmodule

// ===== tb/sv/deadband_change_reporter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadband change reporter testbench
// Drives ticks and channel commands into the reporter, predicts every
// event and acknowledge beat from its own copy of the flags, baselines and
// sweep time, and checks each result beat in order. Register writes and
// read-backs go through the APB port while the block is idle. Directed
// tests, with one long hold-off at the output, cover the corner cases;
// then several random phases run, all but one under stalls on both channels.
// ----------------------------------------------------------------------------
module deadband_change_reporter_tb;

   localparam int CHANNELS    = 4;
   localparam int SETTLE      = 2 * (CHANNELS + 3);
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int SAMPLE_W    = dcr_pkg::SAMPLE_W;
   localparam int TIME_W      = dcr_pkg::TIME_W;
   localparam int CHAN_W      = dcr_pkg::CHAN_W;
   localparam int ROOM_W      = dcr_pkg::ROOM_W;
   localparam int MAX_CH      = dcr_pkg::MAX_CH;
   localparam int PADDR_W     = dcr_pkg::PADDR_W;
   localparam int PDATA_W     = dcr_pkg::PDATA_W;
   localparam int REG_IDX_W   = dcr_pkg::REG_IDX_W;

   typedef struct packed {
      logic [1:0]                      opcode;
      logic [CHAN_W-1:0]               channel;
      logic [TIME_W-1:0]               now_ms;
      logic [MAX_CH-1:0][SAMPLE_W-1:0] level;
      logic [ROOM_W-1:0]               room;
   } req_beat_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [CHAN_W-1:0]   source_channel;
      logic [SAMPLE_W-1:0] reading;
      logic                last;
   } rsp_beat_type;

   logic clock = 1'b0;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic pready;

   dcr_req_if req_bus ();
   dcr_rsp_if rsp_bus ();

   deadband_change_reporter #(.CHANNELS(CHANNELS)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   logic [TIME_W-1:0]          period_ms;
   logic [SAMPLE_W-1:0]        limit_of [MAX_CH];
   logic [MAX_CH-1:0]          subscribed;
   logic [MAX_CH-1:0]          primed;
   logic signed [SAMPLE_W-1:0] baseline [MAX_CH];
   logic [TIME_W-1:0]          sweep_ms;

   rsp_beat_type owed_reports [$];
   int mismatches  = 0;
   int cycle_count = 0;
   bit steady      = 1'b0;
   int hold_len    = 0;
   int hold_left   = 0;

   always #10 clock = ~clock;

   task automatic note_mismatch(input string what);
      mismatches++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   function automatic rsp_beat_type result_of(input logic [1:0] kind, input int ch,
                                              input logic [SAMPLE_W-1:0] reading,
                                              input logic last);
      rsp_beat_type r;
      r.kind           = kind;
      r.source_channel = CHAN_W'(ch);
      r.reading        = reading;
      r.last           = last;
      return r;
   endfunction

   function automatic void compute_reports(input req_beat_type b);
      int room;
      int delta;
      int ch;
      int hits [$];
      logic signed [SAMPLE_W-1:0] level;
      room = (b.room > dcr_pkg::ROOM_MAX) ? int'(dcr_pkg::ROOM_MAX) : int'(b.room);
      if (b.opcode == dcr_pkg::OP_TICK) begin
         if (TIME_W'(b.now_ms - sweep_ms) < period_ms) return;
         sweep_ms = b.now_ms;
         for (ch = 0; ch < CHANNELS; ch++) begin
            if (!subscribed[ch]) continue;
            level = b.level[ch];
            delta = int'(level) - int'(baseline[ch]);
            if (delta < 0) delta = -delta;
            if (primed[ch] && delta < int'(limit_of[ch])) continue;
            if (room == 0) continue;
            room--;
            baseline[ch] = level;
            primed[ch]   = 1'b1;
            hits.push_back(ch);
         end
         foreach (hits[k]) begin
            owed_reports.push_back(result_of(dcr_pkg::KIND_EVENT, hits[k],
                                             b.level[hits[k]], k == hits.size() - 1));
         end
      end else if (b.channel >= CHANNELS) begin
         owed_reports.push_back(result_of(dcr_pkg::KIND_ACK_ERR, b.channel, '0, 1'b1));
      end else begin
         case (b.opcode)
            dcr_pkg::OP_SUBSCRIBE: begin
               subscribed[b.channel] = 1'b1;
               primed[b.channel]     = 1'b0;
               owed_reports.push_back(result_of(dcr_pkg::KIND_ACK_OK, b.channel, '0, 1'b1));
            end
            dcr_pkg::OP_UNSUBSCRIBE: begin
               subscribed[b.channel] = 1'b0;
               owed_reports.push_back(result_of(dcr_pkg::KIND_ACK_OK, b.channel, '0, 1'b1));
            end
            default: begin
               owed_reports.push_back(result_of(dcr_pkg::KIND_ACK_OK, b.channel,
                                                b.level[b.channel], 1'b1));
            end
         endcase
      end
   endfunction

   function automatic logic [PDATA_W-1:0] register_value(input logic [REG_IDX_W-1:0] idx);
      if (idx == dcr_pkg::REG_SAMPLE_PERIOD) return period_ms;
      if (idx >= dcr_pkg::REG_THRESHOLD_0 && idx <= dcr_pkg::REG_THRESHOLD_3)
         return PDATA_W'(limit_of[idx - dcr_pkg::REG_THRESHOLD_0]);
      return '0;
   endfunction

   function automatic req_beat_type tick_beat(input logic [TIME_W-1:0] now, input int l0,
                                              input int l1, input int l2, input int l3,
                                              input int room);
      req_beat_type b;
      b.opcode   = dcr_pkg::OP_TICK;
      b.channel  = CHAN_W'($urandom_range(7));
      b.now_ms   = now;
      b.level[0] = SAMPLE_W'(l0);
      b.level[1] = SAMPLE_W'(l1);
      b.level[2] = SAMPLE_W'(l2);
      b.level[3] = SAMPLE_W'(l3);
      b.room     = ROOM_W'(room);
      return b;
   endfunction

   function automatic req_beat_type command_beat(input logic [1:0] op, input int ch,
                                                 input int value);
      req_beat_type b;
      b.opcode  = op;
      b.channel = CHAN_W'(ch);
      b.now_ms  = $urandom;
      b.room    = ROOM_W'($urandom_range(7));
      for (int k = 0; k < MAX_CH; k++) b.level[k] = SAMPLE_W'($urandom);
      if (ch < MAX_CH) b.level[ch] = SAMPLE_W'(value);
      return b;
   endfunction

   function automatic req_beat_type random_beat();
      req_beat_type b;
      int pick;
      int span;
      b.opcode  = dcr_pkg::OP_TICK;
      b.channel = CHAN_W'($urandom_range(7));
      b.now_ms  = $urandom;
      b.room    = ROOM_W'($urandom_range(7));
      for (int k = 0; k < MAX_CH; k++) b.level[k] = SAMPLE_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 30) begin
         case ($urandom_range(2))
            0:       b.opcode = dcr_pkg::OP_SUBSCRIBE;
            1:       b.opcode = dcr_pkg::OP_UNSUBSCRIBE;
            default: b.opcode = dcr_pkg::OP_READ;
         endcase
         if ($urandom_range(99) < 85) b.channel = CHAN_W'($urandom_range(CHANNELS - 1));
      end else if (pick < 92) begin
         if ($urandom_range(9) < 2)
            b.now_ms = sweep_ms + period_ms - 1 - $urandom_range(2);
         else
            b.now_ms = sweep_ms + period_ms + $urandom_range(3);
         for (int k = 0; k < CHANNELS; k++) begin
            if ($urandom_range(4) != 0) begin
               span = int'(limit_of[k]) + 2;
               b.level[k] = SAMPLE_W'(int'(baseline[k]) + int'($urandom_range(2 * span)) - span);
            end
         end
      end else begin
         b.opcode = 2'($urandom_range(3));
      end
      return b;
   endfunction

   task automatic send_beat(input req_beat_type b);
      int gap;
      if (!steady && $urandom_range(99) < 18) begin
         gap = $urandom_range(1, 4);
         @(negedge clock) req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.opcode    <= b.opcode;
      req_bus.channel   <= b.channel;
      req_bus.now_ms    <= b.now_ms;
      req_bus.sample_0  <= b.level[0];
      req_bus.sample_1  <= b.level[1];
      req_bus.sample_2  <= b.level[2];
      req_bus.sample_3  <= b.level[3];
      req_bus.send_room <= b.room;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      compute_reports(b);
   endtask

   task automatic drain();
      @(negedge clock) req_bus.valid <= 1'b0;
      while (owed_reports.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [REG_IDX_W-1:0] idx,
                             input logic [PDATA_W-1:0] value,
                             output logic [PDATA_W-1:0] got);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= PADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(negedge clock) penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      got = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
      logic [PDATA_W-1:0] unused;
      csr_access(1'b1, idx, value, unused);
      if (idx == dcr_pkg::REG_SAMPLE_PERIOD)
         period_ms = value;
      else if (idx >= dcr_pkg::REG_THRESHOLD_0 && idx <= dcr_pkg::REG_THRESHOLD_3)
         limit_of[idx - dcr_pkg::REG_THRESHOLD_0] = value[SAMPLE_W-1:0];
   endtask

   task automatic check_registers();
      logic [PDATA_W-1:0] got;
      for (int k = int'(dcr_pkg::REG_SAMPLE_PERIOD); k <= int'(dcr_pkg::REG_THRESHOLD_3);
           k++) begin
         csr_access(1'b0, REG_IDX_W'(k), '0, got);
         if (got !== register_value(REG_IDX_W'(k)))
            note_mismatch($sformatf("register %0d reads %h, wanted %h", k, got,
                                    register_value(REG_IDX_W'(k))));
      end
   endtask

   task automatic set_thresholds(input int lo, input int hi);
      for (int k = 0; k < CHANNELS; k++)
         csr_write(REG_IDX_W'(int'(dcr_pkg::REG_THRESHOLD_0) + k),
                   PDATA_W'($urandom_range(lo, hi)));
   endtask

   task automatic test_registers();
      check_registers();
      csr_write(dcr_pkg::REG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
      csr_write(dcr_pkg::REG_THRESHOLD_0, 32'h0000_FFFF);
      csr_write(dcr_pkg::REG_THRESHOLD_1, 32'hA5A5_0000);
      csr_write(dcr_pkg::REG_THRESHOLD_2, 32'h1234_8001);
      csr_write(dcr_pkg::REG_THRESHOLD_3, 32'h0000_7FFE);
      check_registers();
      for (int k = int'(dcr_pkg::REG_THRESHOLD_3) + 1; k < (1 << REG_IDX_W); k++)
         csr_write(REG_IDX_W'(k), 32'h5A5A_5A5A);
      check_registers();
   endtask

   task automatic test_commands();
      for (int ch = 0; ch < CHANNELS; ch++)
         send_beat(command_beat(dcr_pkg::OP_SUBSCRIBE, ch, 0));
      send_beat(command_beat(dcr_pkg::OP_READ, 0, -32768));
      send_beat(command_beat(dcr_pkg::OP_READ, 3, 32767));
      send_beat(command_beat(dcr_pkg::OP_SUBSCRIBE, 4, 0));
      send_beat(command_beat(dcr_pkg::OP_UNSUBSCRIBE, 5, 0));
      send_beat(command_beat(dcr_pkg::OP_READ, 7, 0));
      send_beat(command_beat(dcr_pkg::OP_UNSUBSCRIBE, 2, 0));
      send_beat(command_beat(dcr_pkg::OP_SUBSCRIBE, 2, 0));
   endtask

   task automatic test_sweeps();
      drain();
      csr_write(dcr_pkg::REG_SAMPLE_PERIOD, 32'd0);
      csr_write(dcr_pkg::REG_THRESHOLD_0, 32'd0);
      csr_write(dcr_pkg::REG_THRESHOLD_1, 32'd100);
      csr_write(dcr_pkg::REG_THRESHOLD_2, 32'hFFFF);
      csr_write(dcr_pkg::REG_THRESHOLD_3, 32'd5);
      send_beat(tick_beat(32'd10, 100, -200, -32768, 7, 7));
      send_beat(tick_beat(32'd11, 101, -150, -32768, 12, 0));
      send_beat(tick_beat(32'd12, 101, -101, 32767, 12, 4));
      send_beat(tick_beat(32'd13, 0, 0, 32767, -32768, 1));
      send_beat(command_beat(dcr_pkg::OP_UNSUBSCRIBE, 0, 0));
      send_beat(tick_beat(32'd14, 5, -200, 32767, 12, 4));
      drain();
      csr_write(dcr_pkg::REG_SAMPLE_PERIOD, 32'd1000);
      send_beat(tick_beat(32'd1013, 9, 90, -5, 300, 4));
      send_beat(tick_beat(32'hFFFF_FF00, 0, 50, 32767, 12, 4));
      send_beat(tick_beat(32'h0000_0100, 0, -3000, 0, -400, 4));
      send_beat(tick_beat(32'h0000_02E8, 0, 50, 32767, 20, 4));
   endtask

   task automatic test_backpressure();
      drain();
      csr_write(dcr_pkg::REG_SAMPLE_PERIOD, 32'd0);
      set_thresholds(0, 0);
      for (int ch = 0; ch < CHANNELS; ch++)
         send_beat(command_beat(dcr_pkg::OP_SUBSCRIBE, ch, 0));
      hold_len = HOLD_CYCLES;
      repeat (12) begin
         send_beat(tick_beat($urandom, $urandom, $urandom, $urandom, $urandom,
                             int'(dcr_pkg::ROOM_MAX)));
      end
      drain();
      repeat (4)
         send_beat(command_beat(dcr_pkg::OP_READ, $urandom_range(CHANNELS - 1), $urandom));
   endtask

   task automatic run_phase(input int count);
      repeat (count) send_beat(random_beat());
   endtask

   task automatic test_random_traffic();
      drain();
      csr_write(dcr_pkg::REG_SAMPLE_PERIOD, 32'd0);
      set_thresholds(0, 50);
      run_phase(100);
      drain();
      csr_write(dcr_pkg::REG_SAMPLE_PERIOD, 32'd25);
      set_thresholds(0, 300);
      steady = 1'b1;
      run_phase(90);
      steady = 1'b0;
      drain();
      csr_write(dcr_pkg::REG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
      csr_write(dcr_pkg::REG_THRESHOLD_0, 32'd0);
      csr_write(dcr_pkg::REG_THRESHOLD_1, 32'hFFFF);
      csr_write(dcr_pkg::REG_THRESHOLD_2, 32'd0);
      csr_write(dcr_pkg::REG_THRESHOLD_3, 32'hFFFF);
      run_phase(40);
      drain();
      csr_write(dcr_pkg::REG_SAMPLE_PERIOD, PDATA_W'($urandom_range(1, 5000)));
      set_thresholds(0, 65535);
      run_phase(100);
      drain();
      csr_write(dcr_pkg::REG_SAMPLE_PERIOD, 32'd3);
      set_thresholds(0, 0);
      run_phase(60);
   endtask

   always @(negedge clock) begin
      if (hold_len > 0) begin
         hold_left = hold_len;
         hold_len  = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= steady || ($urandom_range(99) >= 18);
      end
   end

   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (owed_reports.size() == 0) begin
            note_mismatch($sformatf("unexpected result beat: kind %0d channel %0d reading %0d",
                                    rsp_bus.kind, rsp_bus.source_channel, rsp_bus.reading));
         end else begin
            want = owed_reports.pop_front();
            if (rsp_bus.kind !== want.kind || rsp_bus.source_channel !== want.source_channel ||
                rsp_bus.reading !== want.reading || rsp_bus.last !== want.last)
               note_mismatch($sformatf(
                  "result beat kind %0d ch %0d reading %0d last %b, wanted %0d %0d %0d %b",
                  rsp_bus.kind, rsp_bus.source_channel, rsp_bus.reading, rsp_bus.last,
                  want.kind, want.source_channel, $signed(want.reading), want.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("deadband_change_reporter_tb NOT OK");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      req_bus.valid     = 1'b0;
      req_bus.opcode    = dcr_pkg::OP_TICK;
      req_bus.channel   = '0;
      req_bus.now_ms    = '0;
      req_bus.sample_0  = '0;
      req_bus.sample_1  = '0;
      req_bus.sample_2  = '0;
      req_bus.sample_3  = '0;
      req_bus.send_room = '0;
      rsp_bus.ready     = 1'b0;
      period_ms         = '0;
      sweep_ms          = '0;
      subscribed        = '0;
      primed            = '0;
      for (int k = 0; k < MAX_CH; k++) begin
         limit_of[k] = '0;
         baseline[k] = '0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_registers();
      test_commands();
      test_sweeps();
      test_backpressure();
      test_random_traffic();
      drain();
      if (mismatches == 0) begin
         $display("deadband_change_reporter_tb OK");
      end else begin
         $display("deadband_change_reporter_tb NOT OK");
      end
      $finish;
   end

endmodule
